/* design/ght_pkg.sv */
// Shared widths, codes and types of the generational handle table.
package ght_pkg;

  // Fixed widths of the transaction fields.
  localparam int OBJ_W         = 32;
  localparam int TAG_W         = 32;
  localparam int HANDLE_W      = 42;
  localparam int COUNT_W       = 11;
  localparam int STATUS_W      = 3;
  localparam int MAX_SLOT_BITS = 16;

  // Operation codes on the input channel.
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_OCCUPIED = 3'd2,
    ST_OBJECT   = 3'd3,
    ST_TAG      = 3'd4
  } status_t;

  // Command class decided by the front end.
  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_ADD_NULL,
    CMD_REMOVE,
    CMD_REMOVE_NULL
  } cmd_kind_t;

  // Decoded command passed through the queue, fields already masked.
  typedef struct packed {
    cmd_kind_t                kind;
    logic [OBJ_W-1:0]         obj;
    logic [TAG_W-1:0]         tag;
    logic [MAX_SLOT_BITS-1:0] slot;
    logic [TAG_W-1:0]         htag;
  } cmd_t;

endpackage

/* design/ght_if.sv */
// Valid/ready channel interfaces for the request and result transactions.
interface ght_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [ght_pkg::OBJ_W-1:0]  object_ref;
  logic [ght_pkg::TAG_W-1:0]  new_tag;
  logic [ght_pkg::HANDLE_W-1:0] handle_in;

  modport source (output valid, operation, object_ref, new_tag, handle_in, input ready);
  modport sink (input valid, operation, object_ref, new_tag, handle_in, output ready);
endinterface

interface ght_out_if;
  logic                         valid;
  logic                         ready;
  logic [ght_pkg::HANDLE_W-1:0] handle_out;
  logic [ght_pkg::STATUS_W-1:0] status;
  logic [ght_pkg::COUNT_W-1:0]  live_count;

  modport source (output valid, handle_out, status, live_count, input ready);
  modport sink (input valid, handle_out, status, live_count, output ready);
endinterface

/* design/ght_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ght_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

/* design/ght_front.sv */
// Front end: accepts request transactions and classifies them into commands.
module ght_front #(
  parameter int SLOT_BITS   = 10,
  parameter int TAG_BITS    = 32,
  parameter int OBJECT_BITS = 32
) (
  ght_in_if.sink        in_ch,
  input  logic          clr_busy,
  input  logic          q_full,
  output logic          push,
  output ght_pkg::cmd_t push_cmd
);

  localparam int OBJ_SW = (OBJECT_BITS < ght_pkg::OBJ_W) ? OBJECT_BITS : ght_pkg::OBJ_W;

  logic [OBJ_SW-1:0]   obj_m;
  logic [TAG_BITS-1:0] tag_m;
  logic [TAG_BITS-1:0] htag_m;
  logic [SLOT_BITS-1:0] slot_m;

  // Take a transaction only when the table is initialized and the queue has room.
  assign in_ch.ready = !clr_busy && !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  // Mask the fields to the configured widths.
  assign obj_m  = OBJ_SW'(in_ch.object_ref);
  assign tag_m  = TAG_BITS'(in_ch.new_tag);
  assign slot_m = SLOT_BITS'(in_ch.handle_in);
  assign htag_m = TAG_BITS'(in_ch.handle_in >> SLOT_BITS);

  // Classify the request; a zero object can never succeed.
  always_comb begin
    push_cmd.obj  = ght_pkg::OBJ_W'(obj_m);
    push_cmd.tag  = ght_pkg::TAG_W'(tag_m);
    push_cmd.slot = ght_pkg::MAX_SLOT_BITS'(slot_m);
    push_cmd.htag = ght_pkg::TAG_W'(htag_m);
    if (in_ch.operation == ght_pkg::OP_ADD) begin
      push_cmd.kind = (obj_m == '0) ? ght_pkg::CMD_ADD_NULL : ght_pkg::CMD_ADD;
    end else begin
      push_cmd.kind = (obj_m == '0) ? ght_pkg::CMD_REMOVE_NULL : ght_pkg::CMD_REMOVE;
    end
  end

endmodule

/* design/ght_queue.sv */
// Small command queue between the front end and the back end.
module ght_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ght_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output ght_pkg::cmd_t head_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  ght_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  assign full      = (fill_r == FW'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];

  // Pointer wrap and fill tracking.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + FW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* design/ght_back.sv */
// Back end: executes commands against the slot and free-list memories.
module ght_back #(
  parameter int SLOT_BITS   = 10,
  parameter int TAG_BITS    = 32,
  parameter int OBJECT_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  ght_pkg::cmd_t q_cmd,
  output logic          pop,
  output logic          clr_busy,
  ght_out_if.source     out_ch
);

  localparam int SLOT_COUNT = 1 << SLOT_BITS;
  localparam int CNT_W      = SLOT_BITS + 1;
  localparam int OBJ_SW     = (OBJECT_BITS < ght_pkg::OBJ_W) ? OBJECT_BITS : ght_pkg::OBJ_W;
  localparam int ENTRY_W    = OBJ_SW + TAG_BITS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_FL,
    S_ADD_CHK,
    S_REM_CHK,
    S_RESP
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [SLOT_BITS-1:0]        clr_addr_r, clr_addr_nxt;
  ght_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [SLOT_BITS-1:0]        slot_r, slot_nxt;
  ght_pkg::status_t            status_r, status_nxt;
  logic                        wr_ok_r, wr_ok_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ght_pkg::HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  ght_pkg::status_t            out_status_r, out_status_nxt;
  logic [ght_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  logic                 table_full;
  logic                 out_free;
  logic [SLOT_BITS-1:0] head_slot;
  logic [CNT_W-1:0]     count_dec;

  logic                 slot_we;
  logic [SLOT_BITS-1:0] slot_waddr;
  logic [ENTRY_W-1:0]   slot_wdata;
  logic [SLOT_BITS-1:0] slot_raddr;
  logic [ENTRY_W-1:0]   slot_rd;
  logic [OBJ_SW-1:0]    rd_obj;
  logic [TAG_BITS-1:0]  rd_tag;

  logic                 fl_we;
  logic [SLOT_BITS-1:0] fl_waddr;
  logic [SLOT_BITS-1:0] fl_wdata;
  logic [SLOT_BITS-1:0] fl_rd;

  // Slot entries hold {object, tag}.
  ght_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk     (clk),
    .we      (slot_we),
    .waddr   (slot_waddr),
    .wdata   (slot_wdata),
    .raddr   (slot_raddr),
    .rd_data (slot_rd)
  );

  // Stack of free slot numbers, indexed by the live count.
  ght_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOT_COUNT)) u_free_ram (
    .clk     (clk),
    .we      (fl_we),
    .waddr   (fl_waddr),
    .wdata   (fl_wdata),
    .raddr   (count_r[SLOT_BITS-1:0]),
    .rd_data (fl_rd)
  );

  assign table_full = (count_r == CNT_W'(SLOT_COUNT));
  assign out_free   = !out_valid_r || out_ch.ready;
  assign head_slot  = q_cmd.slot[SLOT_BITS-1:0];
  assign count_dec  = count_r - CNT_W'(1);
  assign rd_obj     = slot_rd[ENTRY_W-1:TAG_BITS];
  assign rd_tag     = slot_rd[TAG_BITS-1:0];
  assign clr_busy   = (state_r == S_CLEAR);

  // The slot lookup follows the free-list read on an add.
  assign slot_raddr = (state_r == S_ADD_FL) ? fl_rd : head_slot;

  // Memory writes: the clearing pass, or the commit of a successful command.
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot_r;
    slot_wdata = '0;
    fl_we      = 1'b0;
    fl_waddr   = count_dec[SLOT_BITS-1:0];
    fl_wdata   = slot_r;
    if (state_r == S_CLEAR) begin
      slot_we    = 1'b1;
      slot_waddr = clr_addr_r;
      fl_we      = 1'b1;
      fl_waddr   = clr_addr_r;
      fl_wdata   = clr_addr_r;
    end else if (state_r == S_RESP && out_free && wr_ok_r) begin
      slot_we = 1'b1;
      if (cmd_r.kind == ght_pkg::CMD_ADD) begin
        slot_wdata = {cmd_r.obj[OBJ_SW-1:0], cmd_r.tag[TAG_BITS-1:0]};
      end else begin
        fl_we = 1'b1;
      end
    end
  end

  // Command sequencer.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    clr_addr_nxt   = clr_addr_r;
    cmd_nxt        = cmd_r;
    slot_nxt       = slot_r;
    status_nxt     = status_r;
    wr_ok_nxt      = wr_ok_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_handle_nxt = out_handle_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    pop            = 1'b0;
    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + SLOT_BITS'(1);
        if (clr_addr_r == SLOT_BITS'(SLOT_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          cmd_nxt    = q_cmd;
          slot_nxt   = head_slot;
          wr_ok_nxt  = 1'b0;
          status_nxt = ght_pkg::ST_OBJECT;
          state_nxt  = S_RESP;
          case (q_cmd.kind)
            ght_pkg::CMD_ADD: begin
              if (table_full) begin
                status_nxt = ght_pkg::ST_FULL;
              end else begin
                state_nxt = S_ADD_FL;
              end
            end
            ght_pkg::CMD_ADD_NULL: begin
              status_nxt = table_full ? ght_pkg::ST_FULL : ght_pkg::ST_OBJECT;
            end
            ght_pkg::CMD_REMOVE: begin
              if (count_r != '0) begin
                state_nxt = S_REM_CHK;
              end
            end
            default: begin
              status_nxt = ght_pkg::ST_OBJECT;
            end
          endcase
        end
      end
      S_ADD_FL: begin
        slot_nxt  = fl_rd;
        state_nxt = S_ADD_CHK;
      end
      S_ADD_CHK: begin
        if (rd_obj != '0) begin
          status_nxt = ght_pkg::ST_OCCUPIED;
        end else begin
          status_nxt = ght_pkg::ST_OK;
          wr_ok_nxt  = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_REM_CHK: begin
        if (rd_obj != cmd_r.obj[OBJ_SW-1:0]) begin
          status_nxt = ght_pkg::ST_OBJECT;
        end else if (rd_tag != cmd_r.htag[TAG_BITS-1:0]) begin
          status_nxt = ght_pkg::ST_TAG;
        end else begin
          status_nxt = ght_pkg::ST_OK;
          wr_ok_nxt  = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_handle_nxt = '0;
          if (wr_ok_r && cmd_r.kind == ght_pkg::CMD_ADD) begin
            count_nxt      = count_r + CNT_W'(1);
            out_handle_nxt = ght_pkg::HANDLE_W'({cmd_r.tag[TAG_BITS-1:0], slot_r});
          end else if (wr_ok_r) begin
            count_nxt = count_dec;
          end
          out_count_nxt = ght_pkg::COUNT_W'(count_nxt);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      count_r     <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      wr_ok_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      wr_ok_r     <= wr_ok_nxt;
    end
    cmd_r        <= cmd_nxt;
    slot_r       <= slot_nxt;
    status_r     <= status_nxt;
    out_handle_r <= out_handle_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Result channel is driven straight from the output register.
  assign out_ch.valid      = out_valid_r;
  assign out_ch.handle_out = out_handle_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.live_count = out_count_r;

endmodule

/* design/generational_handle_table_unit.sv */
// Top level of the generational handle table.
//
// Requests arrive on in_ch (valid/ready): an add stores object_ref with new_tag
// in the slot popped from the free-list stack and returns the handle; a remove
// checks object and tag of the slot named by handle_in and frees it. Each request
// yields exactly one result transaction on out_ch with handle, status and count.
// The front end classifies requests into a two-entry command queue; the back end
// executes them one at a time against two RAMs with one write and one read port.
// In the back end, a request rejected up front goes from idle straight to the
// response state, a remove passes through its check state before the response,
// and an add passes through the free-list read, then the dependent slot read,
// then commit. After reset the back end writes every slot empty and every
// free-list entry with its own index; in_ch.ready stays low during that pass.
// A stalled out_ch holds its result in the output register; the back end keeps
// working on the next command and waits only at commit, and the queue keeps
// accepting until it is full.
module generational_handle_table_unit #(
  parameter int SLOT_BITS   = 10,
  parameter int TAG_BITS    = 32,
  parameter int OBJECT_BITS = 32
) (
  input logic        clk,
  input logic        rst_n,
  ght_in_if.sink     in_ch,
  ght_out_if.source  out_ch
);

  logic          push;
  ght_pkg::cmd_t push_cmd;
  logic          q_full;
  logic          q_valid;
  ght_pkg::cmd_t q_cmd;
  logic          pop;
  logic          clr_busy;

  // Request decode.
  ght_front #(
    .SLOT_BITS   (SLOT_BITS),
    .TAG_BITS    (TAG_BITS),
    .OBJECT_BITS (OBJECT_BITS)
  ) u_front (
    .in_ch    (in_ch),
    .clr_busy (clr_busy),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decoupling queue.
  ght_queue #(.DEPTH(2)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head_cmd  (q_cmd)
  );

  // Execution against the table memories.
  ght_back #(
    .SLOT_BITS   (SLOT_BITS),
    .TAG_BITS    (TAG_BITS),
    .OBJECT_BITS (OBJECT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .clr_busy (clr_busy),
    .out_ch   (out_ch)
  );

endmodule
